/* design/rfdrd_pkg.sv */
// ----------------------------------------------------------------------------
// rfdrd_pkg: shared definitions for the rotated frame dirty rectangle detector
// Sizes, register indexes, the end-of-frame result record and size clamping.
// ----------------------------------------------------------------------------
package rfdrd_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int PIXEL_BITS   = 32;
  localparam int SHADOW_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W       = $clog2(SHADOW_DEPTH);

  localparam int CNT_W  = 8;   // loop counters and box corners
  localparam int SIZE_W = 9;   // width / height registers and exclusive bounds
  localparam int IDLE_W = 8;
  localparam int RUN_W  = 16;

  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = SIZE_W'(256);
  localparam logic [1:0]        ROTATION_RST     = 2'd0;
  localparam logic [IDLE_W-1:0] IDLE_THRESH_RST  = IDLE_W'(30);

  // register index = byte address / 4
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_ROTATION_MODE  = 2'd2,
    REG_IDLE_THRESHOLD = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [RUN_W-1:0]  changed_run;
    logic              long_wait;
    logic              frame_dirty;
    logic [SIZE_W-1:0] box_max_y;
    logic [SIZE_W-1:0] box_max_x;
    logic [CNT_W-1:0]  box_min_y;
    logic [CNT_W-1:0]  box_min_x;
  } result_t;

  // zero reads as one, anything above the maximum saturates
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* design/rfdrd_ram.sv */
// ----------------------------------------------------------------------------
// rfdrd_ram: generic simple dual-port RAM
// One write port, one read port, registered read data, read-first on collision.
// ----------------------------------------------------------------------------
module rfdrd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/rotated_frame_dirty_rect_detector_top.sv */
// ----------------------------------------------------------------------------
// rotated_frame_dirty_rect_detector_top: dirty rectangle detector over a
// rotated shadow frame store
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one source pixel per transfer, raster order (column fastest).
//   out_*  : one transfer per frame, after the frame's last pixel, carrying the
//            changed-pixel bounding box in rotated coordinates (exclusive upper
//            bounds), dirty and long-wait flags and the changed-frame run.
//   cfg_*  : APB-style register port, pready tied high; write only while idle.
// Throughput: one pixel per cycle sustained while in_tready is high. Each pixel
//   is a read-modify-write of the 64K x 32 shadow RAM: read issued at the input
//   transfer, compare and write-back in the following cycle. A same-address pixel
//   right behind is served by a one-entry forward path, so no bubble is needed.
// Result path: the compare stage writes the frame result straight into a
//   2-entry output FIFO that drives out_*.
// Reset: rst_n low resets the control and config registers; afterwards the
//   shadow RAM is zeroed one word per cycle, with in_tready low. cfg writes are taken.
// Stall: results wait in the output FIFO; apart from the RAM clear, in_tready
//   drops only when a further frame end could not find a FIFO slot.
// ----------------------------------------------------------------------------
module rotated_frame_dirty_rect_detector_top (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] pixel_value
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [7:0] box_min_x, [15:8] box_min_y,
                                   // [24:16] box_max_x, [33:25] box_max_y,
                                   // [34] frame_dirty, [35] long_wait,
                                   // [51:36] changed_run, [55:52] zero
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rfdrd_pkg::*;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0] width_r, height_r;
  logic [1:0]        rotation_r;
  logic [IDLE_W-1:0] thresh_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= FRAME_WIDTH_RST;
      height_r   <= FRAME_HEIGHT_RST;
      rotation_r <= ROTATION_RST;
      thresh_r   <= IDLE_THRESH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:    width_r    <= cfg_pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT:   height_r   <= cfg_pwdata[SIZE_W-1:0];
        REG_ROTATION_MODE:  rotation_r <= cfg_pwdata[1:0];
        REG_IDLE_THRESHOLD: thresh_r   <= cfg_pwdata[IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:    cfg_prdata = 32'(width_r);
      REG_FRAME_HEIGHT:   cfg_prdata = 32'(height_r);
      REG_ROTATION_MODE:  cfg_prdata = 32'(rotation_r);
      REG_IDLE_THRESHOLD: cfg_prdata = 32'(thresh_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // shadow RAM clear after reset
  // --------------------------------------------------------------------------
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // --------------------------------------------------------------------------
  // stage 0: loop position, rotated coordinates, RAM read
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]    col_r, row_r;
  logic [SIZE_W-1:0]   w_eff, h_eff;
  logic [CNT_W-1:0]    acc_x, acc_y;
  logic [CNT_W-1:0]    base;
  logic [SIZE_W-1:0]   mul_a, mul_b;
  logic [2*SIZE_W-1:0] prod, addr_sum;
  logic [ADDR_W-1:0]   acc_addr;
  logic [SIZE_W-1:0]   col_inc, row_inc;
  logic                col_wrap, row_wrap, acc_eof;
  logic                accept;

  assign w_eff = clamp_size(width_r,  SIZE_W'(MAX_WIDTH));
  assign h_eff = clamp_size(height_r, SIZE_W'(MAX_HEIGHT));

  always_comb begin
    if (rotation_r[0]) begin
      // quarter turn: x = H-1-row, y = col, address = x + col*H
      if ({1'b0, row_r} < h_eff) begin
        acc_x = CNT_W'(h_eff - SIZE_W'(1) - {1'b0, row_r});
      end else begin
        acc_x = '0;
      end
      acc_y = col_r;
      base  = acc_x;
      mul_a = {1'b0, col_r};
      mul_b = h_eff;
    end else begin
      acc_x = col_r;
      acc_y = row_r;
      base  = col_r;
      mul_a = {1'b0, row_r};
      mul_b = w_eff;
    end
    prod     = mul_a * mul_b;
    addr_sum = prod + (2*SIZE_W)'(base);
    acc_addr = addr_sum[ADDR_W-1:0];
  end

  assign col_inc  = {1'b0, col_r} + SIZE_W'(1);
  assign row_inc  = {1'b0, row_r} + SIZE_W'(1);
  assign col_wrap = !(col_inc < w_eff);
  assign row_wrap = !(row_inc < h_eff);
  assign acc_eof  = col_wrap & row_wrap;

  // --------------------------------------------------------------------------
  // stage 1 registers
  // --------------------------------------------------------------------------
  logic                  s1_valid_r, s1_eof_r, s1_fwd_r;
  logic [ADDR_W-1:0]     s1_addr_r;
  logic [PIXEL_BITS-1:0] s1_pix_r, s1_fwd_data_r;
  logic [CNT_W-1:0]      s1_x_r, s1_y_r;
  logic [PIXEL_BITS-1:0] ram_rdata, cur_data;
  logic                  changed;

  // output FIFO
  result_t   fifo_q_r [2];
  logic      fifo_wr_r, fifo_rd_r;
  logic [1:0] fifo_cnt_r;
  logic      push, pop;
  logic [2:0] occ;

  assign push = s1_valid_r & s1_eof_r;
  assign pop  = out_tvalid & out_tready;
  // the pending frame end plus this item's possible one must both fit
  assign occ       = 3'(fifo_cnt_r) + 3'(push);
  assign in_tready = !clearing_r && (occ <= 3'(1) + 3'(pop));
  assign accept    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      s1_valid_r <= accept;
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == '1) begin
          clearing_r <= 1'b0;
        end
      end
      if (accept) begin
        col_r <= col_wrap ? '0 : col_inc[CNT_W-1:0];
        if (col_wrap) begin
          row_r <= row_wrap ? '0 : row_inc[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r     <= acc_addr;
      s1_pix_r      <= in_tdata[PIXEL_BITS-1:0];
      s1_x_r        <= acc_x;
      s1_y_r        <= acc_y;
      s1_eof_r      <= acc_eof;
      // stage 1 writes this address at the same edge the RAM reads it
      s1_fwd_r      <= s1_valid_r && (s1_addr_r == acc_addr);
      s1_fwd_data_r <= s1_pix_r;
    end
  end

  // --------------------------------------------------------------------------
  // shadow RAM
  // --------------------------------------------------------------------------
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [PIXEL_BITS-1:0] ram_wdata;

  assign cur_data = s1_fwd_r ? s1_fwd_data_r : ram_rdata;
  assign changed  = s1_valid_r && (cur_data != s1_pix_r);

  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = changed;
      ram_waddr = s1_addr_r;
      ram_wdata = s1_pix_r;
    end
  end

  rfdrd_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (SHADOW_DEPTH)
  ) u_shadow (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (acc_addr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // bounding box and frame-end bookkeeping
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]  low_x_r, low_y_r, high_x_r, high_y_r;
  logic              any_r;
  logic [IDLE_W-1:0] idle_r;
  logic [RUN_W-1:0]  run_r;

  logic [CNT_W-1:0]  lx, ly, hx, hy;
  logic              any_c;
  logic [IDLE_W-1:0] idle_nxt;
  logic [RUN_W-1:0]  run_nxt;
  result_t           res;

  always_comb begin
    lx    = low_x_r;
    ly    = low_y_r;
    hx    = high_x_r;
    hy    = high_y_r;
    any_c = any_r | changed;
    if (changed) begin
      if (s1_x_r < lx) lx = s1_x_r;
      if (s1_x_r > hx) hx = s1_x_r;
      if (s1_y_r < ly) ly = s1_y_r;
      if (s1_y_r > hy) hy = s1_y_r;
    end
    if (any_c) begin
      idle_nxt = '0;
      run_nxt  = (run_r == '1) ? run_r : run_r + RUN_W'(1);
    end else begin
      idle_nxt = (idle_r == '1) ? idle_r : idle_r + IDLE_W'(1);
      run_nxt  = '0;
    end
    res.box_min_x   = any_c ? lx : '0;
    res.box_min_y   = any_c ? ly : '0;
    res.box_max_x   = any_c ? ({1'b0, hx} + SIZE_W'(1)) : '0;
    res.box_max_y   = any_c ? ({1'b0, hy} + SIZE_W'(1)) : '0;
    res.frame_dirty = any_c;
    res.long_wait   = !any_c && (idle_nxt > thresh_r);
    res.changed_run = run_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_x_r  <= '1;
      low_y_r  <= '1;
      high_x_r <= '0;
      high_y_r <= '0;
      any_r    <= 1'b0;
      idle_r   <= '0;
      run_r    <= '0;
    end else if (s1_valid_r) begin
      if (s1_eof_r) begin
        low_x_r  <= '1;
        low_y_r  <= '1;
        high_x_r <= '0;
        high_y_r <= '0;
        any_r    <= 1'b0;
        idle_r   <= idle_nxt;
        run_r    <= run_nxt;
      end else begin
        low_x_r  <= lx;
        low_y_r  <= ly;
        high_x_r <= hx;
        high_y_r <= hy;
        any_r    <= any_c;
      end
    end
  end

  // --------------------------------------------------------------------------
  // output FIFO, two entries
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_wr_r  <= 1'b0;
      fifo_rd_r  <= 1'b0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) fifo_wr_r <= ~fifo_wr_r;
      if (pop)  fifo_rd_r <= ~fifo_rd_r;
      fifo_cnt_r <= fifo_cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_q_r[fifo_wr_r] <= res;
    end
  end

  result_t head;
  assign head       = fifo_q_r[fifo_rd_r];
  assign out_tvalid = (fifo_cnt_r != '0);
  assign out_tdata  = {4'b0000, head.changed_run, head.long_wait, head.frame_dirty,
                       head.box_max_y, head.box_max_x, head.box_min_y, head.box_min_x};

endmodule
